/* rtl/msvis_pkg.sv */
// shared types and codes for the multiset value index store
// no dependencies
package msvis_pkg;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_COUNT  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FIND1,
		S_COUNT1,
		S_ADD,
		S_FIRST,
		S_SHIFT,
		S_FIND2,
		S_COUNT2,
		S_DONE
	} state_t;

	typedef struct packed {
		logic write;
		logic shift;
		logic dec;
	} idx_cmd_t;

	typedef struct packed {
		logic write;
		logic shift;
	} val_cmd_t;

endpackage

/* rtl/msvis_val_cell.sv */
// one cell of the distinct value chain
// depends on msvis_pkg
module msvis_val_cell import msvis_pkg::*; #(
	parameter int SW  = 6,
	parameter int DW  = 7,
	parameter int IDX = 0,
	parameter bit LAST = 1'b0
) (
	input  logic              clk,
	input  val_cmd_t          cmd,
	input  logic [DW-1:0]     fill,
	input  logic [SW-1:0]     slot,
	input  logic [31:0]       wr_value,
	input  logic [31:0]       next_value,
	output logic [31:0]       value,
	output logic              hit
);

	logic [31:0] value_q;

	assign value = value_q;
	assign hit   = (value_q == wr_value) && (DW'(IDX) < fill);

	always_ff @(posedge clk) begin
		if (cmd.write && fill == DW'(IDX)) begin
			value_q <= wr_value;
		end else if (cmd.shift && !LAST && SW'(IDX) >= slot) begin
			value_q <= next_value;
		end
	end

endmodule

/* rtl/msvis_idx_cell.sv */
// one cell of the occurrence index chain
// depends on msvis_pkg
module msvis_idx_cell import msvis_pkg::*; #(
	parameter int SW  = 6,
	parameter int CW  = 9,
	parameter int TAW = 8,
	parameter int IDX = 0,
	parameter bit LAST = 1'b0
) (
	input  logic              clk,
	input  idx_cmd_t          cmd,
	input  logic [CW-1:0]     fill,
	input  logic [TAW-1:0]    pos,
	input  logic [SW-1:0]     slot,
	input  logic [SW-1:0]     wr_slot,
	input  logic [SW-1:0]     next_idx,
	output logic [SW-1:0]     idx,
	output logic              hit
);

	logic [SW-1:0] idx_q;
	logic [SW-1:0] moved;

	assign idx = idx_q;
	assign hit = (idx_q == slot) && (CW'(IDX) < fill);

	always_comb begin
		moved = (!LAST && TAW'(IDX) >= pos) ? next_idx : idx_q;
		if (cmd.dec && moved > slot) begin
			moved = moved - SW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write && fill == CW'(IDX)) begin
			idx_q <= wr_slot;
		end else if (cmd.shift) begin
			idx_q <= moved;
		end
	end

endmodule

/* rtl/multiset_value_index_store_core.sv */
// top level of the multiset value index store: control sequencer and cell chains
// depends on msvis_pkg, msvis_val_cell, msvis_idx_cell
// A bag of 32-bit values held as a chain of distinct-value cells and a chain of
// occurrence-index cells. One word is taken at a time; the time it takes is set
// by the pointer scans along the two chains (lookup before and after the change,
// occurrence count, first-match search). Shifts and index fix-ups happen in all
// cells at once. The result waits in an output register and a stalled result
// holds off the next word.
module multiset_value_index_store_core import msvis_pkg::*; #(
	parameter int DISTINCT_DEPTH = 64,
	parameter int TOTAL_DEPTH    = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        flag,
	output logic [8:0]  occurrences,
	output logic [8:0]  total_size,
	output logic        is_empty,
	output logic        refused_full
);

	localparam int SW  = $clog2(DISTINCT_DEPTH);
	localparam int DW  = $clog2(DISTINCT_DEPTH + 1);
	localparam int TAW = $clog2(TOTAL_DEPTH);
	localparam int CW  = $clog2(TOTAL_DEPTH + 1);
	localparam int PW  = (CW > DW) ? CW : DW;

	state_t state_q, state_d;
	op_t    op_q;
	logic [31:0] value_q;
	logic [CW-1:0]  occ_q, cnt_q;
	logic [DW-1:0]  dc_q;
	logic [PW-1:0]  ptr_q;
	logic [SW-1:0]  slot_q, wr_slot;
	logic [TAW-1:0] pos_q;
	logic found_q, flag_q, ref_q;
	logic out_valid_q, out_flag_q, out_empty_q, out_ref_q;
	logic [8:0] out_occ_q, out_total_q;

	logic [31:0]   vals [DISTINCT_DEPTH];
	logic [SW-1:0] idxs [TOTAL_DEPTH];
	logic [DISTINCT_DEPTH-1:0] vhit;
	logic [TOTAL_DEPTH-1:0]    ihit;
	val_cmd_t vcmd;
	idx_cmd_t icmd;

	logic v_end, v_hit, i_end, i_hit, refuse, last, out_free;

	assign v_end    = ptr_q >= PW'(dc_q);
	assign v_hit    = !v_end && vhit[ptr_q[SW-1:0]];
	assign i_end    = ptr_q >= PW'(occ_q);
	assign i_hit    = !i_end && ihit[ptr_q[TAW-1:0]];
	assign refuse   = (occ_q >= CW'(TOTAL_DEPTH)) ||
		(!found_q && dc_q >= DW'(DISTINCT_DEPTH));
	assign last     = cnt_q == CW'(1);
	assign wr_slot  = found_q ? slot_q : dc_q[SW-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = state_q != S_IDLE;

	// cell chains
	for (genvar j = 0; j < DISTINCT_DEPTH; j++) begin : g_val
		msvis_val_cell #(
			.SW(SW), .DW(DW), .IDX(j), .LAST(j == DISTINCT_DEPTH - 1)
		) u_cell (
			.clk        (clk),
			.cmd        (vcmd),
			.fill       (dc_q),
			.slot       (slot_q),
			.wr_value   (value_q),
			.next_value (vals[(j + 1) % DISTINCT_DEPTH]),
			.value      (vals[j]),
			.hit        (vhit[j])
		);
	end

	for (genvar i = 0; i < TOTAL_DEPTH; i++) begin : g_idx
		msvis_idx_cell #(
			.SW(SW), .CW(CW), .TAW(TAW), .IDX(i), .LAST(i == TOTAL_DEPTH - 1)
		) u_cell (
			.clk      (clk),
			.cmd      (icmd),
			.fill     (occ_q),
			.pos      (pos_q),
			.slot     (slot_q),
			.wr_slot  (wr_slot),
			.next_idx (idxs[(i + 1) % TOTAL_DEPTH]),
			.idx      (idxs[i]),
			.hit      (ihit[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_FIND1;
			end
			S_FIND1: begin
				if (v_end || v_hit) begin
					case (op_q)
						OP_ADD:    state_d = S_ADD;
						OP_REMOVE: state_d = v_hit ? S_COUNT1 : S_DONE;
						default:   state_d = v_hit ? S_COUNT2 : S_DONE;
					endcase
				end
			end
			S_COUNT1: begin
				if (i_end) state_d = (cnt_q == '0) ? S_DONE : S_FIRST;
			end
			S_ADD:    state_d = S_FIND2;
			S_FIRST: begin
				if (i_hit) state_d = S_SHIFT;
			end
			S_SHIFT:  state_d = S_FIND2;
			S_FIND2: begin
				if (v_end || v_hit) state_d = v_hit ? S_COUNT2 : S_DONE;
			end
			S_COUNT2: begin
				if (i_end) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// cell commands
	always_comb begin
		vcmd = '0;
		icmd = '0;
		case (state_q)
			S_ADD: begin
				vcmd.write = !refuse && !found_q;
				icmd.write = !refuse;
			end
			S_SHIFT: begin
				vcmd.shift = last;
				icmd.shift = 1'b1;
				icmd.dec   = last;
			end
			default: begin
				vcmd = '0;
				icmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			dc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_ADD: begin
					if (!refuse) begin
						occ_q <= occ_q + CW'(1);
						if (!found_q) dc_q <= dc_q + DW'(1);
					end
				end
				S_SHIFT: begin
					occ_q <= occ_q - CW'(1);
					if (last) dc_q <= dc_q - DW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= op_t'(op);
				value_q <= value;
				ptr_q   <= '0;
				flag_q  <= 1'b0;
				ref_q   <= 1'b0;
				found_q <= 1'b0;
				cnt_q   <= '0;
			end
			S_FIND1, S_FIND2: begin
				found_q <= v_hit;
				slot_q  <= ptr_q[SW-1:0];
				cnt_q   <= '0;
				ptr_q   <= (v_end || v_hit) ? '0 : ptr_q + PW'(1);
			end
			S_COUNT1, S_COUNT2: begin
				if (!i_end) begin
					cnt_q <= cnt_q + CW'(i_hit);
					ptr_q <= ptr_q + PW'(1);
				end else begin
					ptr_q <= '0;
					if (state_q == S_COUNT2 && op_q != OP_ADD && op_q != OP_REMOVE) begin
						flag_q <= cnt_q != '0;
					end
				end
			end
			S_ADD: begin
				ref_q  <= refuse;
				flag_q <= !refuse;
				if (!found_q) slot_q <= dc_q[SW-1:0];
			end
			S_FIRST: begin
				pos_q <= ptr_q[TAW-1:0];
				ptr_q <= i_hit ? '0 : ptr_q + PW'(1);
			end
			S_SHIFT: begin
				flag_q <= 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					out_flag_q  <= flag_q;
					out_occ_q   <= 9'(found_q ? cnt_q : '0);
					out_total_q <= 9'(occ_q);
					out_empty_q <= (occ_q == '0) && (dc_q == '0);
					out_ref_q   <= ref_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign flag         = out_flag_q;
	assign occurrences  = out_occ_q;
	assign total_size   = out_total_q;
	assign is_empty     = out_empty_q;
	assign refused_full = out_ref_q;

`ifndef NO_ASSERTIONS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(TOTAL_DEPTH))
		else $error("occurrence count beyond depth");
	a_dc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dc_q <= DW'(DISTINCT_DEPTH) && PW'(dc_q) <= PW'(occ_q))
		else $error("distinct count inconsistent");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word not from done state");
`endif

endmodule
